// File: sv/nor_flash_array_model_macros.svh
// Assertion macros shared by the NOR flash array model RTL.
// No dependencies; included by the controller and the datapath.
`ifndef NOR_FLASH_ARRAY_MODEL_MACROS_SVH
`define NOR_FLASH_ARRAY_MODEL_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define NFA_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define NFA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/nfa_pkg.sv
// Package for the NOR flash array model: widths, action codes, states,
// controller command and datapath status structs. No dependencies.
package nfa_pkg;

  // Default array geometry. PAGE_BYTES must be a power of two.
  localparam int FLASH_BYTES_DEF = 131072;
  localparam int PAGE_BYTES_DEF  = 1024;

  // Fixed field widths of the item channels.
  localparam int ACTION_W = 3;
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 8;
  localparam int BLEN_W   = 32;
  localparam int BIDX_W   = 17;
  localparam int VALUE_W  = 32;

  // Erased contents and the reset header.
  localparam logic [DATA_W-1:0]  BYTE_ERASED = 8'hFF;
  localparam logic [VALUE_W-1:0] WORD_ERASED = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0]  HDR_BYTE0   = 8'h08;
  localparam logic [DATA_W-1:0]  HDR_BYTE1   = 8'hAA;
  localparam logic [DATA_W-1:0]  HDR_BYTE2   = 8'h55;
  localparam logic [DATA_W-1:0]  HDR_BYTE3   = 8'h08;
  localparam int HDR_BYTES = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ_BYTE = 3'd0,
    ACT_READ_WORD = 3'd1,
    ACT_PROGRAM   = 3'd2,
    ACT_ERASE     = 3'd3,
    ACT_VERIFY    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_LATCH,
    ST_ERASE,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;    // write the reset image at the sweep counter
    logic cnt_clr;    // zero the sweep / byte counter
    logic cnt_inc;    // advance the counter
    logic load_item;  // capture the accepted input item
    logic mem_rd;     // read the array at base plus counter
    logic latch;      // consume read data (capture, program, verify)
    logic erase_wr;   // write an erased byte at page start plus counter
    logic out_load;   // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic oor;          // current item lies out of range
    logic clear_last;   // counter at the last array byte
    logic page_last;    // counter at the last page byte
    logic word_last;    // counter at the last byte of a word
    logic out_free;     // result register can take a new result
  } dp_status_t;

  // Reset image of the header bytes.
  function automatic logic [DATA_W-1:0] header_byte(input logic [1:0] idx);
    logic [DATA_W-1:0] b;
    unique case (idx)
      2'd0:    b = HDR_BYTE0;
      2'd1:    b = HDR_BYTE1;
      2'd2:    b = HDR_BYTE2;
      default: b = HDR_BYTE3;
    endcase
    return b;
  endfunction

endpackage

// File: sv/nfa_if.sv
// Item channel interfaces of the NOR flash array model (valid/ready).
// Depends on nfa_pkg for the field widths.
interface nfa_in_if;
  import nfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   data_byte;
  logic [BLEN_W-1:0]   burst_length;
  logic [BIDX_W-1:0]   burst_index;

  modport source (output valid, action, address, data_byte, burst_length,
                  burst_index, input ready);
  modport sink   (input valid, action, address, data_byte, burst_length,
                  burst_index, output ready);
endinterface

interface nfa_out_if;
  import nfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_value;
  logic               out_of_range;
  logic               all_match;

  modport source (output valid, read_value, out_of_range, all_match, input ready);
  modport sink   (input valid, read_value, out_of_range, all_match, output ready);
endinterface

// File: sv/nfa_ctrl.sv
// Controller state machine of the NOR flash array model.
// Depends on nfa_pkg and nor_flash_array_model_macros.svh.
`include "nor_flash_array_model_macros.svh"
module nfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nfa_pkg::dp_status_t status,
  output nfa_pkg::ctrl_cmd_t  cmd
);
  import nfa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (status.action == ACT_VERIFY) begin
          state_nxt = ST_READ;
        end else if (status.action == ACT_ERASE) begin
          state_nxt = status.oor ? ST_DONE : ST_ERASE;
        end else if (status.action == ACT_READ_BYTE || status.action == ACT_READ_WORD ||
                     status.action == ACT_PROGRAM) begin
          state_nxt = status.oor ? ST_DONE : ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        if (status.action == ACT_READ_WORD && !status.word_last) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ERASE: begin
        if (status.page_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.init_wr = 1'b1;
        cmd.cnt_inc = !status.clear_last;
        cmd.cnt_clr = status.clear_last;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECODE: begin
        cmd.cnt_clr = 1'b1;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
      end
      ST_LATCH: begin
        cmd.latch   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_ERASE: begin
        cmd.erase_wr = 1'b1;
        cmd.cnt_inc  = !status.page_last;
        cmd.cnt_clr  = status.page_last;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Read data is only consumed right after it was requested.
  `NFA_ASSERT_SAME(a_latch_after_read, clk, rst_n, state_r == ST_LATCH, $past(state_r) == ST_READ, "latch without a preceding read")
  // An erase sweep only runs on a page inside the array.
  `NFA_ASSERT_SAME(a_erase_in_range, clk, rst_n, state_r == ST_ERASE, !status.oor, "erase sweep on an out-of-range page")

endmodule

// File: sv/nfa_datapath.sv
// Datapath of the NOR flash array model: item registers, range checks,
// byte array memory, sweep counter, verify flag and result register.
// Depends on nfa_pkg, nfa_if and nor_flash_array_model_macros.svh.
`include "nor_flash_array_model_macros.svh"
module nfa_datapath #(
  parameter int FLASH_BYTES = nfa_pkg::FLASH_BYTES_DEF,
  parameter int PAGE_BYTES  = nfa_pkg::PAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [nfa_pkg::ACTION_W-1:0] in_action,
  input  logic [nfa_pkg::ADDR_W-1:0]   in_address,
  input  logic [nfa_pkg::DATA_W-1:0]   in_data_byte,
  input  logic [nfa_pkg::BLEN_W-1:0]   in_burst_length,
  input  logic [nfa_pkg::BIDX_W-1:0]   in_burst_index,
  input  nfa_pkg::ctrl_cmd_t           cmd,
  output nfa_pkg::dp_status_t          status,
  nfa_out_if.source                    out_ch
);
  import nfa_pkg::*;

  localparam int AW = $clog2(FLASH_BYTES);
  localparam logic [ADDR_W:0] FLASH_LIMIT = (ADDR_W+1)'(FLASH_BYTES);
  localparam logic [ADDR_W:0] PAGE_SPAN   = (ADDR_W+1)'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

  logic [ACTION_W-1:0] action_r;
  logic [ADDR_W-1:0]   address_r;
  logic [DATA_W-1:0]   data_r;
  logic [BLEN_W-1:0]   blen_r;
  logic [BIDX_W-1:0]   bidx_r;
  logic [AW-1:0]       cnt_r;
  logic [DATA_W-1:0]   rd_data_r;
  logic [VALUE_W-1:0]  word_r;
  logic                verify_ok_r;
  logic                out_valid_r;
  logic [VALUE_W-1:0]  read_value_r;
  logic                oor_r;
  logic                match_r;

  logic [DATA_W-1:0]   mem [FLASH_BYTES];

  logic [ADDR_W-1:0]   page_addr;
  logic [ADDR_W-1:0]   addr_plus_idx;
  logic                rb_oor;
  logic                rw_oor;
  logic                pg_oor;
  logic                er_oor;
  logic                vf_oor;
  logic                oor;
  logic [AW-1:0]       base;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic [DATA_W-1:0]   mem_wdata;
  logic [DATA_W-1:0]   vf_got;
  logic                verify_ok_nxt;
  logic [VALUE_W-1:0]  read_value_nxt;

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r  <= in_action;
      address_r <= in_address;
      data_r    <= in_data_byte;
      blen_r    <= in_burst_length;
      bidx_r    <= in_burst_index;
    end
  end

  // Range checks, all formed one bit wider so that no sum wraps.
  always_comb begin
    page_addr     = address_r & ~PAGE_MASK;
    addr_plus_idx = address_r + ADDR_W'(bidx_r);
    rb_oor = {1'b0, address_r} >= FLASH_LIMIT;
    rw_oor = ({1'b0, address_r} + (ADDR_W+1)'(3)) >= FLASH_LIMIT;
    pg_oor = (({1'b0, address_r} + {1'b0, blen_r}) > FLASH_LIMIT) ||
             (BLEN_W'(bidx_r) >= blen_r);
    er_oor = ({1'b0, page_addr} + PAGE_SPAN) > FLASH_LIMIT;
    vf_oor = ({1'b0, address_r} + (ADDR_W+1)'(bidx_r)) >= FLASH_LIMIT;
    unique case (action_r)
      ACT_READ_BYTE: oor = rb_oor;
      ACT_READ_WORD: oor = rw_oor;
      ACT_PROGRAM:   oor = pg_oor;
      ACT_ERASE:     oor = er_oor;
      ACT_VERIFY:    oor = vf_oor;
      default:       oor = 1'b0;
    endcase
  end

  // Array address: base of the access plus the running counter.
  always_comb begin
    if (cmd.init_wr) begin
      base = '0;
    end else begin
      unique case (action_r)
        ACT_ERASE:   base = page_addr[AW-1:0];
        ACT_PROGRAM: base = addr_plus_idx[AW-1:0];
        ACT_VERIFY:  base = addr_plus_idx[AW-1:0];
        default:     base = address_r[AW-1:0];
      endcase
    end
    mem_addr = base + cnt_r;
  end

  // Write port: reset image, erase, or program (stored AND data).
  always_comb begin
    mem_we = cmd.init_wr || cmd.erase_wr || (cmd.latch && action_r == ACT_PROGRAM);
    if (cmd.init_wr) begin
      mem_wdata = (cnt_r < AW'(HDR_BYTES)) ? header_byte(cnt_r[1:0]) : BYTE_ERASED;
    end else if (cmd.erase_wr) begin
      mem_wdata = BYTE_ERASED;
    end else begin
      mem_wdata = rd_data_r & data_r;
    end
  end

  // Byte array with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Sweep and byte counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  // Assemble read bytes into the word, little-endian.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      word_r[{cnt_r[1:0], 3'b000} +: DATA_W] <= rd_data_r;
    end
  end

  // Running all-match flag; a miss compares as an erased byte.
  always_comb begin
    vf_got        = vf_oor ? BYTE_ERASED : rd_data_r;
    verify_ok_nxt = ((bidx_r == '0) || verify_ok_r) && (vf_got == data_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verify_ok_r <= 1'b1;
    end else if (cmd.latch && action_r == ACT_VERIFY) begin
      verify_ok_r <= verify_ok_nxt;
    end
  end

  // Result value for the finished item.
  always_comb begin
    unique case (action_r)
      ACT_READ_BYTE: read_value_nxt = oor ? VALUE_W'(BYTE_ERASED)
                                          : {{(VALUE_W-DATA_W){1'b0}}, word_r[DATA_W-1:0]};
      ACT_READ_WORD: read_value_nxt = oor ? WORD_ERASED : word_r;
      default:       read_value_nxt = '0;
    endcase
  end

  // Result register; it holds until the item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value_r <= read_value_nxt;
      oor_r        <= oor;
      match_r      <= (action_r == ACT_VERIFY) && verify_ok_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_value   = read_value_r;
  assign out_ch.out_of_range = oor_r;
  assign out_ch.all_match    = match_r;

  // Status toward the controller.
  always_comb begin
    status.action     = action_r;
    status.oor        = oor;
    status.clear_last = cnt_r == AW'(FLASH_BYTES - 1);
    status.page_last  = cnt_r == AW'(PAGE_BYTES - 1);
    status.word_last  = cnt_r[1:0] == 2'd3;
    status.out_free   = !out_valid_r || out_ch.ready;
  end

  // A new result never overwrites one that is still waiting.
  `NFA_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ch.ready, "result register overwritten")
  // Programming only touches bursts that lie inside the array.
  `NFA_ASSERT_SAME(a_program_in_range, clk, rst_n, cmd.latch && action_r == ACT_PROGRAM, !pg_oor, "program write outside the array")

endmodule

// File: sv/nor_flash_array_model.sv
// Top level of the NOR flash array model: controller plus datapath.
// Depends on nfa_pkg, nfa_if, nfa_ctrl and nfa_datapath.
//
//   channel  direction  handshake    payload
//   in_ch    sink       valid/ready  action, address, data_byte, burst_length, burst_index
//   out_ch   source     valid/ready  read_value, out_of_range, all_match
//
// One item at a time: byte read, program and verify each read and latch one byte, word
// read runs four read/latch pairs on the single array port, page erase writes one byte
// per cycle across the page, and rejected or unknown items go straight to the result.
// After reset a clearing pass writes the reset image with in_ch.ready low. The result
// register lets the next item be accepted while a result waits; a second result stalls
// the controller until out_ch is taken.
module nor_flash_array_model #(
  parameter int FLASH_BYTES = nfa_pkg::FLASH_BYTES_DEF,
  parameter int PAGE_BYTES  = nfa_pkg::PAGE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nfa_in_if.sink    in_ch,
  nfa_out_if.source out_ch
);
  import nfa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  nfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Array, checks and result register.
  nfa_datapath #(
    .FLASH_BYTES (FLASH_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_ch.action),
    .in_address      (in_ch.address),
    .in_data_byte    (in_ch.data_byte),
    .in_burst_length (in_ch.burst_length),
    .in_burst_index  (in_ch.burst_index),
    .cmd             (cmd),
    .status          (status),
    .out_ch          (out_ch)
  );

endmodule

// File: sim/nor_flash_array_model_checker.sv
// Checker for the NOR flash array model: watches both item channels, keeps a
// shadow copy of the array and compares every result with its prediction.
// Depends on nfa_pkg and the channel interfaces in nfa_if.
module nor_flash_array_model_checker #(
  parameter int FLASH_BYTES = nfa_pkg::FLASH_BYTES_DEF,
  parameter int PAGE_BYTES  = nfa_pkg::PAGE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  nfa_in_if    in_ch,
  nfa_out_if   out_ch,
  output int   fail_count,
  output int   awaited_count
);
  import nfa_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               out_of_range;
    logic               all_match;
  } flash_result_t;

  // Shadow of the array contents and of the running verify flag.
  logic [DATA_W-1:0] shadow_array [FLASH_BYTES];
  logic              verify_flag;

  // Results predicted for accepted items, oldest first.
  flash_result_t awaited_results [$];

  // Applies one action to the shadow array and returns the result it gives.
  // All range sums are formed in 64 bits so that no 32-bit wrap hides a miss.
  function automatic flash_result_t apply_flash_action(
    input action_t             act,
    input logic [ADDR_W-1:0]   addr,
    input logic [DATA_W-1:0]   data,
    input logic [BLEN_W-1:0]   blen,
    input logic [BIDX_W-1:0]   bidx
  );
    flash_result_t     res;
    logic [63:0]       span;
    logic [63:0]       page_base;
    logic [DATA_W-1:0] stored;
    int                at;
    res = '0;
    case (act)
      ACT_READ_BYTE: begin
        if (64'(addr) >= 64'(FLASH_BYTES)) begin
          res.read_value   = {24'd0, BYTE_ERASED};
          res.out_of_range = 1'b1;
        end else begin
          res.read_value = {24'd0, shadow_array[int'(addr)]};
        end
      end
      ACT_READ_WORD: begin
        span = 64'(addr) + 64'd3;
        if (span >= 64'(FLASH_BYTES)) begin
          res.read_value   = WORD_ERASED;
          res.out_of_range = 1'b1;
        end else begin
          at = int'(addr);
          res.read_value = {shadow_array[at + 3], shadow_array[at + 2],
                            shadow_array[at + 1], shadow_array[at]};
        end
      end
      ACT_PROGRAM: begin
        // Programming only clears bits; a burst that does not fit is dropped.
        span = 64'(addr) + 64'(blen);
        if (span > 64'(FLASH_BYTES) || 64'(bidx) >= 64'(blen)) begin
          res.out_of_range = 1'b1;
        end else begin
          at = int'(addr) + int'(bidx);
          shadow_array[at] = shadow_array[at] & data;
        end
      end
      ACT_ERASE: begin
        page_base = 64'(addr) - (64'(addr) % 64'(PAGE_BYTES));
        if (page_base + 64'(PAGE_BYTES) > 64'(FLASH_BYTES)) begin
          res.out_of_range = 1'b1;
        end else begin
          for (int i = 0; i < PAGE_BYTES; i++) begin
            shadow_array[int'(page_base) + i] = BYTE_ERASED;
          end
        end
      end
      ACT_VERIFY: begin
        // The first byte of a burst restarts the running match flag.
        if (bidx == '0) begin
          verify_flag = 1'b1;
        end
        span = 64'(addr) + 64'(bidx);
        if (span >= 64'(FLASH_BYTES)) begin
          stored           = BYTE_ERASED;
          res.out_of_range = 1'b1;
        end else begin
          stored = shadow_array[int'(span)];
        end
        if (stored != data) begin
          verify_flag = 1'b0;
        end
        res.all_match = verify_flag;
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  // Results are checked before the item of the same edge is predicted, since
  // a result can never leave in the cycle its item is accepted.
  always @(posedge clk) begin
    flash_result_t want;
    flash_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < FLASH_BYTES; i++) begin
        shadow_array[i] = BYTE_ERASED;
      end
      shadow_array[0] = HDR_BYTE0;
      shadow_array[1] = HDR_BYTE1;
      shadow_array[2] = HDR_BYTE2;
      shadow_array[3] = HDR_BYTE3;
      verify_flag = 1'b1;
      awaited_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.read_value, out_ch.out_of_range, out_ch.all_match};
        if (awaited_results.size() == 0) begin
          $error("result item with no item awaiting it: read_value %h", got.read_value);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value expected %h actual %h", want.read_value, got.read_value);
            fail_count++;
          end
          if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range expected %b actual %b",
                   want.out_of_range, got.out_of_range);
            fail_count++;
          end
          if (got.all_match !== want.all_match) begin
            $error("all_match expected %b actual %b", want.all_match, got.all_match);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        awaited_results.push_back(apply_flash_action(action_t'(in_ch.action),
          in_ch.address, in_ch.data_byte, in_ch.burst_length, in_ch.burst_index));
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

// File: sim/nor_flash_array_model_tb.sv
// Testbench top for the NOR flash array model: clock, reset, item stimulus,
// receiver stalls and the verdict. Depends on nfa_pkg, nfa_if, the block and
// nor_flash_array_model_checker.
module nor_flash_array_model_tb;
  import nfa_pkg::*;

  localparam int FLASH_BYTES    = FLASH_BYTES_DEF;
  localparam int PAGE_BYTES     = PAGE_BYTES_DEF;
  localparam int PHASE_ITEMS    = 100;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = PAGE_BYTES + 32;
  // Covers the clearing pass after reset several times over.
  localparam int WATCHDOG_LIMIT = 4 * FLASH_BYTES;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SENDER_GAPS,
    PH_RECEIVER_STALLS,
    PH_BOTH_IDLE
  } traffic_phase_t;

  logic clk = 1'b0;
  logic rst_n;

  nfa_in_if  in_ch ();
  nfa_out_if out_ch ();

  int             fail_count;
  int             awaited_count;
  int             quiet_cycles = 0;
  int             items_sent = 0;
  traffic_phase_t phase = PH_STEADY;
  // Long receiver holds asked for by the sender and served by the receiver.
  int             hold_requests = 0;
  int             holds_done = 0;

  // Last program burst, kept so that verify bursts can hit it.
  logic [ADDR_W-1:0] burst_base = '0;
  int                burst_len = 1;
  logic [DATA_W-1:0] burst_bytes [8];

  nor_flash_array_model #(
    .FLASH_BYTES (FLASH_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nor_flash_array_model_checker #(
    .FLASH_BYTES (FLASH_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offers one item after a random gap and returns once it is accepted.
  task automatic offer_item(input action_t act, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data,
                            input logic [BLEN_W-1:0] blen,
                            input logic [BIDX_W-1:0] bidx);
    int idle_pct;
    idle_pct = (phase == PH_SENDER_GAPS) ? 56 : (phase == PH_BOTH_IDLE) ? 14 : 0;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.address      <= addr;
    in_ch.data_byte    <= data;
    in_ch.burst_length <= blen;
    in_ch.burst_index  <= bidx;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // One traffic phase of random sequences, with one long receiver hold in
  // the middle, then a pause until every result of the phase has come.
  task automatic run_phase(input traffic_phase_t ph, input int count);
    int                first;
    int                kind;
    int                len;
    int                extra;
    bit                hold_issued;
    logic [ADDR_W-1:0] base;
    logic [DATA_W-1:0] vbyte;
    first       = items_sent;
    hold_issued = 1'b0;
    phase       = ph;
    while (items_sent - first < count) begin
      if (!hold_issued && items_sent - first >= count / 2) begin
        hold_requests++;
        hold_issued = 1'b1;
      end
      // Most traffic lands in the first pages or the last page of the array.
      base = (($urandom_range(4) == 4) ? (FLASH_BYTES - PAGE_BYTES)
                                       : $urandom_range(3) * PAGE_BYTES)
             + $urandom_range(PAGE_BYTES - 1);
      kind = $urandom_range(99);
      if (kind < 30) begin
        // Program burst; now and then one index runs past its end.
        len   = $urandom_range(1, 8);
        extra = ($urandom_range(7) == 0) ? 1 : 0;
        burst_base = base;
        burst_len  = len;
        for (int i = 0; i < len + extra; i++) begin
          vbyte = DATA_W'($urandom);
          if (i < len) begin
            burst_bytes[i] = vbyte;
          end
          offer_item(ACT_PROGRAM, base, vbyte, BLEN_W'(len), BIDX_W'(i));
        end
      end else if (kind < 50) begin
        // Verify burst over the last program burst or over erased bytes.
        if ($urandom_range(1) == 1) begin
          for (int i = 0; i < burst_len; i++) begin
            vbyte = burst_bytes[i];
            if ($urandom_range(9) == 0) begin
              vbyte = vbyte ^ (8'h01 << $urandom_range(7));
            end
            offer_item(ACT_VERIFY, burst_base, vbyte, $urandom, BIDX_W'(i));
          end
        end else begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            offer_item(ACT_VERIFY, base, BYTE_ERASED, $urandom, BIDX_W'(i));
          end
        end
      end else if (kind < 72) begin
        if ($urandom_range(1) == 1) begin
          base = burst_base + $urandom_range(7);
        end
        offer_item(($urandom_range(1) == 1) ? ACT_READ_WORD : ACT_READ_BYTE,
                   base, DATA_W'($urandom), $urandom, BIDX_W'($urandom_range(131071)));
      end else if (kind < 77) begin
        offer_item(ACT_ERASE, base, DATA_W'($urandom), $urandom,
                   BIDX_W'($urandom_range(131071)));
      end else begin
        // Noise: any action with fields drawn from their whole ranges.
        case ($urandom_range(2))
          0:       base = $urandom;
          1:       base = FLASH_BYTES - $urandom_range(8);
          default: base = $urandom_range(FLASH_BYTES - 1);
        endcase
        offer_item(action_t'($urandom_range(4)), base, DATA_W'($urandom),
                   ($urandom_range(1) == 1) ? $urandom : $urandom_range(16),
                   BIDX_W'($urandom_range(131071)));
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (awaited_count == 0);
  endtask

  // Receiver: random stalls by phase, or one long hold on request.
  initial begin
    int stall_pct;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall_pct = (phase == PH_RECEIVER_STALLS) ? 56 : (phase == PH_BOTH_IDLE) ? 14 : 0;
      if (holds_done != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("nor_flash_array_model: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_READ_BYTE;
    in_ch.address      = '0;
    in_ch.data_byte    = '0;
    in_ch.burst_length = '0;
    in_ch.burst_index  = '0;
    burst_bytes[0]     = HDR_BYTE0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset header, then byte and word reads at and past the array end.
    for (int i = 0; i < HDR_BYTES; i++) begin
      offer_item(ACT_READ_BYTE, i, 8'h00, 32'd0, 17'd0);
    end
    offer_item(ACT_READ_WORD, 32'd0, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_READ_BYTE, FLASH_BYTES - 1, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_READ_BYTE, FLASH_BYTES, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_READ_BYTE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 17'h1FFFF);
    offer_item(ACT_READ_WORD, FLASH_BYTES - 4, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_READ_WORD, FLASH_BYTES - 3, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_READ_WORD, 32'hFFFF_FFFF, 8'h00, 32'd0, 17'd0);

    // Program a two-byte burst, an index past its end, bursts that overrun
    // the array or wrap 32 bits, and one that ends exactly at the array end.
    offer_item(ACT_PROGRAM, 32'h100, 8'h5A, 32'd2, 17'd0);
    offer_item(ACT_PROGRAM, 32'h100, 8'hA5, 32'd2, 17'd1);
    offer_item(ACT_PROGRAM, 32'h100, 8'h00, 32'd2, 17'd2);
    offer_item(ACT_PROGRAM, FLASH_BYTES - 1, 8'h00, 32'd2, 17'd0);
    offer_item(ACT_PROGRAM, 32'hFFFF_FFFF, 8'h00, 32'd2, 17'd0);
    offer_item(ACT_PROGRAM, 32'd0, 8'h00, 32'hFFFF_FFFF, 17'd0);
    offer_item(ACT_PROGRAM, FLASH_BYTES - 2, 8'h00, 32'd2, 17'd1);
    offer_item(ACT_READ_WORD, 32'hFF, 8'h00, 32'd0, 17'd0);

    // Verify: match, mismatch, restart, and bytes beyond the array.
    offer_item(ACT_VERIFY, 32'h100, 8'h5A, 32'd0, 17'd0);
    offer_item(ACT_VERIFY, 32'h100, 8'h00, 32'd0, 17'd1);
    offer_item(ACT_VERIFY, 32'h100, 8'h5A, 32'd0, 17'd0);
    offer_item(ACT_VERIFY, FLASH_BYTES - 1, 8'hFF, 32'd0, 17'd1);
    offer_item(ACT_VERIFY, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 17'h1FFFF);

    // Erase the first page from inside it, the last page, and pages beyond.
    offer_item(ACT_ERASE, 32'd5, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_READ_WORD, 32'd0, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_ERASE, FLASH_BYTES - 1, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_ERASE, FLASH_BYTES, 8'h00, 32'd0, 17'd0);
    offer_item(ACT_ERASE, 32'hFFFF_FFFF, 8'h00, 32'd0, 17'd0);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (awaited_count == 0);

    run_phase(PH_STEADY, PHASE_ITEMS);
    run_phase(PH_SENDER_GAPS, PHASE_ITEMS);
    run_phase(PH_RECEIVER_STALLS, PHASE_ITEMS);
    run_phase(PH_BOTH_IDLE, PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("nor_flash_array_model: match");
    end else begin
      $display("nor_flash_array_model: mismatch");
    end
    $finish;
  end

endmodule

// File: nor_flash_array_model.f
+incdir+sv
sv/nfa_pkg.sv
sv/nfa_if.sv
sv/nfa_ctrl.sv
sv/nfa_datapath.sv
sv/nor_flash_array_model.sv
sim/nor_flash_array_model_checker.sv
sim/nor_flash_array_model_tb.sv
